### sv/sharp_pkg.sv
// ----------------------------------------------------------------------------
// sharp_pkg
// shared constants and types of the 3x3 sharpen convolution unit
// ----------------------------------------------------------------------------
package sharp_pkg;

    localparam int PIX_W          = 8;
    localparam int WIDTH_REG_W    = 11;
    localparam int HEIGHT_REG_W   = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_INDEX_W    = 1;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int MIN_SIZE       = 3;

    localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH  = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = 13'd480;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // kernel: centre weight, edge neighbours subtract, corners unused
    localparam int CENTER_WEIGHT = 5;
    localparam int PIX_MAX       = 255;
    localparam int SUM_W         = 12;

    typedef struct packed {
        logic produce;
        logic last;
    } pos_ctl_t;

endpackage

### sv/sharp_pix_if.sv
// ----------------------------------------------------------------------------
// sharp_pix_if
// input pixel channel: valid/ready with one raster pixel per transaction
// ----------------------------------------------------------------------------
interface sharp_pix_if;

    logic                        valid;
    logic                        ready;
    logic [sharp_pkg::PIX_W-1:0] pixel_in;
    logic                        start_of_frame;

    modport source (output valid, output pixel_in, output start_of_frame, input ready);
    modport sink   (input valid, input pixel_in, input start_of_frame, output ready);

endinterface

### sv/sharp_res_if.sv
// ----------------------------------------------------------------------------
// sharp_res_if
// result channel: sharpened pixel with its position in the frame
// ----------------------------------------------------------------------------
interface sharp_res_if #(
    parameter int ROW_W = $clog2(sharp_pkg::MAX_HEIGHT_DEF),
    parameter int COL_W = $clog2(sharp_pkg::MAX_WIDTH_DEF)
);

    logic                        valid;
    logic                        ready;
    logic [sharp_pkg::PIX_W-1:0] pixel_out;
    logic [ROW_W-1:0]            out_row;
    logic [COL_W-1:0]            out_col;
    logic                        last_of_frame;

    modport source (output valid, output pixel_out, output out_row, output out_col,
                    output last_of_frame, input ready);
    modport sink   (input valid, input pixel_out, input out_row, input out_col,
                    input last_of_frame, output ready);

endinterface

### sv/sharpen_3x3_convolution_unit.sv
// ----------------------------------------------------------------------------
// sharpen_3x3_convolution_unit
// 3x3 sharpen filter over a raster stream of 8-bit grayscale pixels
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless the result side stalls, and emits the clamped
// sharpened value of the window centre one row up and one column left, for
// interior pixels only. An accepted pixel reads its column from the line memory at
// the accept edge, is combined with the window in the next cycle, and its result
// is loaded into the output register when stage one advances. The rate is set by
// the single read-modify-write of the line memory per pixel (a column written back
// in the same cycle it is read again is bypassed inside the memory). Border pixels
// produce no result transaction. start_of_frame restarts the position counters;
// image_width and image_height may only change between frames.
module sharpen_3x3_convolution_unit #(
    parameter int MAX_WIDTH  = sharp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sharp_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    sharp_pix_if.sink                         pixels,
    sharp_res_if.source                       results,
    input  logic                              cfg_we,
    input  logic [sharp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sharp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int PW    = sharp_pkg::PIX_W;

    logic                 in_fire;
    logic                 out_free;
    logic                 s1_adv;

    logic [COL_W-1:0]     col_cur;
    logic [ROW_W-1:0]     row_m1;
    logic [COL_W-1:0]     col_m1;
    sharp_pkg::pos_ctl_t  pos_ctl;

    logic                 s1_valid_reg, s1_valid_next;
    logic [PW-1:0]        s1_px_reg;
    logic [COL_W-1:0]     s1_col_reg;
    logic [ROW_W-1:0]     s1_row_m1_reg;
    logic [COL_W-1:0]     s1_col_m1_reg;
    sharp_pkg::pos_ctl_t  s1_ctl_reg;

    logic [2*PW-1:0]      ram_q;
    logic [PW-1:0]        win_pixel;

    logic                 out_valid_reg, out_valid_next;
    logic [PW-1:0]        out_pixel_reg;
    logic [ROW_W-1:0]     out_row_reg;
    logic [COL_W-1:0]     out_col_reg;
    logic                 out_last_reg;

    // stage one moves on unless its result has nowhere to go
    assign out_free      = !out_valid_reg || results.ready;
    assign s1_adv        = s1_valid_reg && (!s1_ctl_reg.produce || out_free);
    assign pixels.ready  = !s1_valid_reg || s1_adv;
    assign in_fire       = pixels.valid && pixels.ready;

    sharp_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (in_fire),
        .sof       (pixels.start_of_frame),
        .col_cur   (col_cur),
        .row_m1    (row_m1),
        .col_m1    (col_m1),
        .ctl       (pos_ctl)
    );

    // write back: upper line takes the old lower entry, lower takes the new pixel
    sharp_line_ram #(
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data ({ram_q[PW-1:0], s1_px_reg}),
        .rd_en   (in_fire),
        .rd_addr (col_cur),
        .rd_data (ram_q)
    );

    sharp_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (s1_adv),
        .top   (ram_q[2*PW-1:PW]),
        .mid   (ram_q[PW-1:0]),
        .bot   (s1_px_reg),
        .pixel (win_pixel)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_adv && s1_ctl_reg.produce)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_ctl_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (in_fire)
                s1_ctl_reg <= pos_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_px_reg     <= pixels.pixel_in;
            s1_col_reg    <= col_cur;
            s1_row_m1_reg <= row_m1;
            s1_col_m1_reg <= col_m1;
        end
        if (s1_adv && s1_ctl_reg.produce)
        begin
            out_pixel_reg <= win_pixel;
            out_row_reg   <= s1_row_m1_reg;
            out_col_reg   <= s1_col_m1_reg;
            out_last_reg  <= s1_ctl_reg.last;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.pixel_out     = out_pixel_reg;
    assign results.out_row       = out_row_reg;
    assign results.out_col       = out_col_reg;
    assign results.last_of_frame = out_last_reg;

`ifndef SYNTHESIS
    // an interior pixel leaving stage one lands in the output register
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_ctl_reg.produce) |=>
            (out_valid_reg && (out_pixel_reg == $past(win_pixel))))
        else $error("interior pixel result not loaded into output register");

    // a result always names an interior position
    a_interior_pos: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> ((results.out_row != '0) && (results.out_col != '0)))
        else $error("result transaction at a border position");

    // the produce flag of an accepted pixel reaches stage one
    a_produce_carried: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && pos_ctl.produce) |=> (s1_valid_reg && s1_ctl_reg.produce))
        else $error("produce flag lost between accept and stage one");
`endif

endmodule

### sv/sharp_line_ram.sv
// ----------------------------------------------------------------------------
// sharp_line_ram
// both line stores in one word: upper line in the high byte, lower in the low
// ----------------------------------------------------------------------------
module sharp_line_ram #(
    parameter int DEPTH = sharp_pkg::MAX_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [$clog2(DEPTH)-1:0]            wr_addr,
    input  logic [2*sharp_pkg::PIX_W-1:0]       wr_data,
    input  logic                                rd_en,
    input  logic [$clog2(DEPTH)-1:0]            rd_addr,
    output logic [2*sharp_pkg::PIX_W-1:0]       rd_data
);

    logic [2*sharp_pkg::PIX_W-1:0] mem [DEPTH];
    logic [2*sharp_pkg::PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // write-first bypass covers a read of the column being written back
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/sharp_pos.sv
// ----------------------------------------------------------------------------
// sharp_pos
// size registers and raster position counters
// ----------------------------------------------------------------------------
module sharp_pos #(
    parameter int MAX_WIDTH  = sharp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sharp_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sharp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sharp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                step,
    input  logic                                sof,
    output logic [$clog2(MAX_WIDTH)-1:0]        col_cur,
    output logic [$clog2(MAX_HEIGHT)-1:0]       row_m1,
    output logic [$clog2(MAX_WIDTH)-1:0]        col_m1,
    output sharp_pkg::pos_ctl_t                 ctl
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int CW1   = COL_W + 1;
    localparam int RW1   = ROW_W + 1;
    localparam int WC    = (CW1 > sharp_pkg::WIDTH_REG_W) ? CW1 : sharp_pkg::WIDTH_REG_W;
    localparam int HC    = (RW1 > sharp_pkg::HEIGHT_REG_W) ? RW1 : sharp_pkg::HEIGHT_REG_W;

    logic [sharp_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [sharp_pkg::HEIGHT_REG_W-1:0] height_reg;
    logic [COL_W-1:0]                   col_reg, col_next;
    logic [ROW_W-1:0]                   row_reg, row_next;

    logic [WC-1:0]    w_raw;
    logic [HC-1:0]    h_raw;
    logic [CW1-1:0]   w_eff;
    logic [RW1-1:0]   h_eff;
    logic [ROW_W-1:0] row_cur;
    logic             col_end;
    logic             row_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sharp_pkg::RESET_WIDTH;
            height_reg <= sharp_pkg::RESET_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sharp_pkg::REG_IMAGE_WIDTH:
                    width_reg <= cfg_data[sharp_pkg::WIDTH_REG_W-1:0];
                sharp_pkg::REG_IMAGE_HEIGHT:
                    height_reg <= cfg_data[sharp_pkg::HEIGHT_REG_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // saturate sizes to 3..max
    assign w_raw = WC'(width_reg);
    assign h_raw = HC'(height_reg);

    always_comb
    begin
        if (w_raw < WC'(sharp_pkg::MIN_SIZE))
            w_eff = CW1'(sharp_pkg::MIN_SIZE);
        else if (w_raw > WC'(MAX_WIDTH))
            w_eff = CW1'(MAX_WIDTH);
        else
            w_eff = w_raw[CW1-1:0];

        if (h_raw < HC'(sharp_pkg::MIN_SIZE))
            h_eff = RW1'(sharp_pkg::MIN_SIZE);
        else if (h_raw > HC'(MAX_HEIGHT))
            h_eff = RW1'(MAX_HEIGHT);
        else
            h_eff = h_raw[RW1-1:0];
    end

    // position of the current pixel; an axis beyond a shrunk size restarts
    always_comb
    begin
        if (sof || ({1'b0, col_reg} >= w_eff))
            col_cur = '0;
        else
            col_cur = col_reg;

        if (sof || ({1'b0, row_reg} >= h_eff))
            row_cur = '0;
        else
            row_cur = row_reg;

        col_end = ({1'b0, col_cur} == (w_eff - CW1'(1)));
        row_end = ({1'b0, row_cur} == (h_eff - RW1'(1)));

        if (col_end)
        begin
            col_next = '0;
            row_next = row_end ? '0 : row_cur + ROW_W'(1);
        end
        else
        begin
            col_next = col_cur + COL_W'(1);
            row_next = row_cur;
        end

        row_m1      = row_cur - ROW_W'(1);
        col_m1      = col_cur - COL_W'(1);
        ctl.produce = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
        ctl.last    = row_end && col_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (step)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

### sv/sharp_window.sv
// ----------------------------------------------------------------------------
// sharp_window
// window of the two previous columns and the sharpen kernel with clamping
// ----------------------------------------------------------------------------
module sharp_window (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        shift,
    input  logic [sharp_pkg::PIX_W-1:0] top,
    input  logic [sharp_pkg::PIX_W-1:0] mid,
    input  logic [sharp_pkg::PIX_W-1:0] bot,
    output logic [sharp_pkg::PIX_W-1:0] pixel
);

    localparam int SW = sharp_pkg::SUM_W;

    // column c-1: top, centre, bottom; column c-2: centre only is needed
    logic [sharp_pkg::PIX_W-1:0] top1_reg, mid1_reg, bot1_reg, mid2_reg;
    logic signed [SW-1:0]        sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top1_reg <= '0;
            mid1_reg <= '0;
            bot1_reg <= '0;
            mid2_reg <= '0;
        end
        else if (shift)
        begin
            mid2_reg <= mid1_reg;
            top1_reg <= top;
            mid1_reg <= mid;
            bot1_reg <= bot;
        end
    end

    always_comb
    begin
        sum = $signed(SW'(mid1_reg) * SW'(sharp_pkg::CENTER_WEIGHT))
            - $signed(SW'(top1_reg))
            - $signed(SW'(bot1_reg))
            - $signed(SW'(mid2_reg))
            - $signed(SW'(mid));
        if (sum[SW-1])
            pixel = '0;
        else if (sum > $signed(SW'(sharp_pkg::PIX_MAX)))
            pixel = sharp_pkg::PIX_W'(sharp_pkg::PIX_MAX);
        else
            pixel = sum[sharp_pkg::PIX_W-1:0];
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the 3x3 sharpen convolution unit
// ----------------------------------------------------------------------------
// Streams raster pixels through the unit under several frame sizes and flow
// patterns. A behavioral sharpen filter follows every accepted input
// transaction and queues the interior result it implies. Each result
// transaction is checked field by field against the oldest queued result.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_W          = sharp_pkg::MAX_WIDTH_DEF;
    localparam int MAX_H          = sharp_pkg::MAX_HEIGHT_DEF;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct packed {
        logic [sharp_pkg::PIX_W-1:0] pixel;
        logic                        sof;
    } raster_pixel_t;

    typedef struct packed {
        logic [sharp_pkg::PIX_W-1:0] pixel;
        logic [11:0]                 row;
        logic [9:0]                  col;
        logic                        last;
    } sharpened_t;

    typedef enum {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SINK_STALL, FLOW_BOTH} flow_t;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_we;
    logic [sharp_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [sharp_pkg::CFG_DATA_W-1:0]  cfg_data;

    sharp_pix_if pix_ch ();
    sharp_res_if res_ch ();

    sharpen_3x3_convolution_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pix_ch),
        .results   (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    raster_pixel_t pixel_queue[$];
    sharpened_t    pending_sharpened[$];
    raster_pixel_t next_pixel;
    sharpened_t    predicted;
    sharpened_t    oldest;

    int  src_idle_pct;
    int  sink_stall_pct;
    int  fail_count;
    int  quiet_cycles;
    bit  pix_taken;
    bit  res_taken;

    // filter state
    logic [sharp_pkg::WIDTH_REG_W-1:0]  cfg_width  = sharp_pkg::RESET_WIDTH;
    logic [sharp_pkg::HEIGHT_REG_W-1:0] cfg_height = sharp_pkg::RESET_HEIGHT;
    logic [sharp_pkg::PIX_W-1:0]        upper_line [MAX_W];
    logic [sharp_pkg::PIX_W-1:0]        lower_line [MAX_W];
    bit                                 upper_ok   [MAX_W];
    bit                                 lower_ok   [MAX_W];
    logic [sharp_pkg::PIX_W-1:0]        win        [6];
    int                                 row_pos;
    int                                 col_pos;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int clamp_dim(input int v, input int hi);
        if (v < sharp_pkg::MIN_SIZE)
            return sharp_pkg::MIN_SIZE;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // win[0..2]: top, middle, bottom of column c-1; win[3..5]: column c-2
    function automatic bit sharpen_step(input logic [sharp_pkg::PIX_W-1:0] px,
                                        input logic sof, output sharpened_t res);
        int w;
        int h;
        int r;
        int c;
        int sum;
        bit made;
        logic [sharp_pkg::PIX_W-1:0] top;
        logic [sharp_pkg::PIX_W-1:0] mid;
        w    = clamp_dim(cfg_width, MAX_W);
        h    = clamp_dim(cfg_height, MAX_H);
        res  = '0;
        made = 1'b0;
        if (sof)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        if (col_pos >= w)
            col_pos = 0;
        if (row_pos >= h)
            row_pos = 0;
        r   = row_pos;
        c   = col_pos;
        top = upper_line[c];
        mid = lower_line[c];
        if (r >= 2 && c >= 2)
        begin
            sum = sharp_pkg::CENTER_WEIGHT * int'(win[1]) - int'(win[0]) - int'(win[2])
                  - int'(win[4]) - int'(mid);
            if (sum > sharp_pkg::PIX_MAX)
                sum = sharp_pkg::PIX_MAX;
            else if (sum < 0)
                sum = 0;
            res.pixel = sum[sharp_pkg::PIX_W-1:0];
            res.row   = 12'(r - 1);
            res.col   = 10'(c - 1);
            res.last  = (r == h - 1) && (c == w - 1);
            made      = 1'b1;
        end
        upper_line[c] = mid;
        upper_ok[c]   = lower_ok[c];
        lower_line[c] = px;
        lower_ok[c]   = 1'b1;
        win[3] = win[0];
        win[4] = win[1];
        win[5] = win[2];
        win[0] = top;
        win[1] = mid;
        win[2] = px;
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        col_pos = c;
        row_pos = r;
        return made;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // pixel driver and ready generator
    always @(negedge clk)
    begin
        if (!rst_n)
            pix_ch.valid <= 1'b0;
        else if (!pix_ch.valid || pix_taken)
        begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                next_pixel = pixel_queue.pop_front();
                pix_ch.valid          <= 1'b1;
                pix_ch.pixel_in       <= next_pixel.pixel;
                pix_ch.start_of_frame <= next_pixel.sof;
            end
            else
                pix_ch.valid <= 1'b0;
        end
        res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // monitor: prediction on input transactions, checking on result transactions
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            pix_taken = pix_ch.valid && pix_ch.ready;
            res_taken = res_ch.valid && res_ch.ready;
            if (pix_taken)
            begin
                if (sharpen_step(pix_ch.pixel_in, pix_ch.start_of_frame, predicted))
                    pending_sharpened.push_back(predicted);
            end
            if (res_taken)
            begin
                if (pending_sharpened.size() == 0)
                begin
                    $display("%0t: unexpected result, pixel %0d row %0d col %0d last %0d",
                             $time, res_ch.pixel_out, res_ch.out_row, res_ch.out_col,
                             res_ch.last_of_frame);
                    fail_count++;
                end
                else
                begin
                    oldest = pending_sharpened.pop_front();
                    check_field("pixel_out", oldest.pixel, res_ch.pixel_out);
                    check_field("out_row", oldest.row, res_ch.out_row);
                    check_field("out_col", oldest.col, res_ch.out_col);
                    check_field("last_of_frame", oldest.last, res_ch.last_of_frame);
                end
            end
            if (pix_taken || res_taken || (pixel_queue.size() == 0 && !pix_ch.valid
                                           && pending_sharpened.size() == 0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // checked at the rising edge, where the driver's outputs have settled
    task automatic drain();
        while (pixel_queue.size() != 0 || pix_ch.valid || pending_sharpened.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // wait for idle, then write both size registers and pick the flow pattern
    task automatic start_phase(input int w_val, input int h_val, input flow_t flow);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= sharp_pkg::REG_IMAGE_WIDTH;
        cfg_data  <= w_val[sharp_pkg::CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_index <= sharp_pkg::REG_IMAGE_HEIGHT;
        cfg_data  <= h_val[sharp_pkg::CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we     <= 1'b0;
        cfg_width  = w_val[sharp_pkg::WIDTH_REG_W-1:0];
        cfg_height = h_val[sharp_pkg::HEIGHT_REG_W-1:0];
        src_idle_pct   = (flow == FLOW_SRC_IDLE)   ? 58 : (flow == FLOW_BOTH) ? 19 : 0;
        sink_stall_pct = (flow == FLOW_SINK_STALL) ? 58 : (flow == FLOW_BOTH) ? 19 : 0;
    endtask

    task automatic queue_frame3(input logic [sharp_pkg::PIX_W-1:0] centre,
                                input logic [sharp_pkg::PIX_W-1:0] up,
                                input logic [sharp_pkg::PIX_W-1:0] left,
                                input logic [sharp_pkg::PIX_W-1:0] right,
                                input logic [sharp_pkg::PIX_W-1:0] down,
                                input logic [sharp_pkg::PIX_W-1:0] corner,
                                input bit sof);
        pixel_queue.push_back('{corner, sof});
        pixel_queue.push_back('{up, 1'b0});
        pixel_queue.push_back('{corner, 1'b0});
        pixel_queue.push_back('{left, 1'b0});
        pixel_queue.push_back('{centre, 1'b0});
        pixel_queue.push_back('{right, 1'b0});
        pixel_queue.push_back('{corner, 1'b0});
        pixel_queue.push_back('{down, 1'b0});
        pixel_queue.push_back('{corner, 1'b0});
    endtask

    // raster pixels with random content; noise adds stray frame starts
    task automatic queue_random(input int count, input bit lead_sof, input bit noise);
        int w;
        bit stores_valid;
        raster_pixel_t item;
        w = clamp_dim(cfg_width, MAX_W);
        stores_valid = 1'b1;
        // a frame that carries on without a start flag must only see written line columns
        for (int c = 0; c < w; c++)
            if (!upper_ok[c] || !lower_ok[c])
                stores_valid = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(9))
                0, 1:    item.pixel = '0;
                2, 3:    item.pixel = '1;
                4:       item.pixel = 8'($urandom_range(255, 240));
                5:       item.pixel = 8'($urandom_range(15));
                default: item.pixel = 8'($urandom_range(255));
            endcase
            item.sof = (i == 0 && (lead_sof || !stores_valid))
                       || (noise && $urandom_range(299) == 0);
            pixel_queue.push_back(item);
        end
    endtask

    initial
    begin
        int w_val;
        int h_val;
        rst_n                 = 1'b0;
        pix_ch.valid          = 1'b0;
        pix_ch.pixel_in       = '0;
        pix_ch.start_of_frame = 1'b0;
        res_ch.ready          = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = sharp_pkg::REG_IMAGE_WIDTH;
        cfg_data              = '0;
        src_idle_pct          = 0;
        sink_stall_pct        = 0;
        fail_count            = 0;
        quiet_cycles          = 0;
        pix_taken             = 1'b0;
        res_taken             = 1'b0;
        row_pos               = 0;
        col_pos               = 0;
        for (int c = 0; c < MAX_W; c++)
        begin
            upper_line[c] = '0;
            lower_line[c] = '0;
            upper_ok[c]   = 1'b0;
            lower_ok[c]   = 1'b0;
        end
        for (int k = 0; k < 6; k++)
            win[k] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // smallest frame: clamp high, clamp low, corners ignored; second frame wraps
        start_phase(3, 3, FLOW_FREE);
        queue_frame3(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        queue_frame3(8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        queue_frame3(8'd60, 8'd50, 8'd40, 8'd30, 8'd20, 8'd255, 1'b1);

        start_phase(5, 4, FLOW_SRC_IDLE);
        queue_random(80, 1'b1, 1'b1);
        // shrink in mid-frame without a start flag
        start_phase(4, 3, FLOW_SINK_STALL);
        queue_random(60, 1'b0, 1'b0);
        // width register zero saturates to 3, height beyond max saturates to 4096
        start_phase(13'h1800, 13'h1fff, FLOW_FREE);
        queue_random(300, 1'b1, 1'b0);
        // width beyond max saturates to the line length, height below minimum
        start_phase(13'h07ff, 1, FLOW_BOTH);
        queue_random(200, 1'b1, 1'b0);
        start_phase(MAX_W, sharp_pkg::MIN_SIZE, FLOW_SRC_IDLE);
        queue_random(150, 1'b0, 1'b1);

        for (int i = 0; i < 14; i++)
        begin
            w_val = ($urandom_range(5) == 0) ? $urandom_range(2) : $urandom_range(14, 3);
            if ($urandom_range(3) == 0)
                w_val += 2048 * $urandom_range(3, 1);
            case ($urandom_range(7))
                0:       h_val = $urandom_range(2);
                1:       h_val = $urandom_range(8191, 4097);
                default: h_val = $urandom_range(9, 3);
            endcase
            start_phase(w_val, h_val, flow_t'(i % 4));
            queue_random($urandom_range(100, 30), $urandom_range(1), 1'b1);
        end

        drain();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
sv/sharp_pkg.sv
sv/sharp_pix_if.sv
sv/sharp_res_if.sv
sv/sharp_line_ram.sv
sv/sharp_pos.sv
sv/sharp_window.sv
sv/sharpen_3x3_convolution_unit.sv
verif/testbench.sv
